FILE: hw/rtl/tcce_pkg.sv
// tcce_pkg: shared constants, codes and controller/datapath interface types
// for the text console cursor engine. No dependencies.

package tcce_pkg;

   // screen geometry
   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int TAB_STOP = 8;
   localparam int CELLS    = COLUMNS * ROWS;

   localparam int ADDR_W  = $clog2(CELLS);
   localparam int COL_W   = $clog2(COLUMNS);

   // field widths
   localparam int OPCODE_W = 2;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int COLOR_W  = 4;
   localparam int CELL_W   = 11;
   localparam int CELL_DATA_W = CHAR_W + ATTR_W;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

   // register indexes
   localparam logic REG_FG_COLOR = 1'b0;
   localparam logic REG_BG_COLOR = 1'b1;

   // character codes
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LINE_FEED = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LAST_PRINT = 8'h7F;

   localparam logic [ATTR_W-1:0]  RESET_ATTR = 8'h0F;
   localparam logic [COLOR_W-1:0] RESET_FG   = 4'hF;
   localparam logic [COLOR_W-1:0] RESET_BG   = 4'h0;

   typedef struct packed {
      logic capture;       // latch the accepted item
      logic exec;          // carry out the item's own step
      logic sweep_start;   // start a pass over the whole store
      logic fill_reset;    // pass fills with the reset attribute, no shift
      logic rsp_load;      // load the output register
   } ctl_cmd_type;

   typedef struct packed {
      logic need_sweep;
      logic sweep_done;
      logic rsp_busy;
   } ctl_status_type;

endpackage

FILE: hw/rtl/tcce_ctrl.sv
// tcce_ctrl: sequencing state machine of the text console cursor engine.
// Depends on tcce_pkg for the command and status types.

module tcce_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tcce_pkg::ctl_status_type status,
   output tcce_pkg::ctl_cmd_type    cmd
);
   import tcce_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_INIT_WAIT,
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd             = '0;
      cmd.capture     = (state_ff == ST_IDLE) && req_valid;
      cmd.exec        = (state_ff == ST_EXEC);
      cmd.sweep_start = (state_ff == ST_INIT) ||
                        ((state_ff == ST_EXEC) && status.need_sweep);
      cmd.fill_reset  = (state_ff == ST_INIT);
      cmd.rsp_load    = (state_ff == ST_DONE) && !status.rsp_busy;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT:      state_in = ST_INIT_WAIT;
         ST_INIT_WAIT: if (status.sweep_done) state_in = ST_IDLE;
         ST_IDLE:      if (req_valid) state_in = ST_EXEC;
         ST_EXEC:      state_in = status.need_sweep ? ST_SWEEP : ST_DONE;
         ST_SWEEP:     if (status.sweep_done) state_in = ST_DONE;
         ST_DONE:      if (!status.rsp_busy) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/tcce_datapath.sv
// tcce_datapath: cell store, cursor arithmetic, store sweep and output register
// of the text console cursor engine. Depends on tcce_pkg.

module tcce_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tcce_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [tcce_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tcce_pkg::CELL_W-1:0]       req_cell_index,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [tcce_pkg::COLOR_W-1:0]      csr_wr_data,
   input  tcce_pkg::ctl_cmd_type             cmd,
   output tcce_pkg::ctl_status_type          status,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [tcce_pkg::CELL_W-1:0]       rsp_cursor_position,
   output logic [tcce_pkg::CHAR_W-1:0]       rsp_read_char,
   output logic [tcce_pkg::ATTR_W-1:0]       rsp_read_attribute,
   output logic                              rsp_scrolled
);
   import tcce_pkg::*;

   localparam int CUR_X_W = ADDR_W + 1;
   localparam int COL_X_W = COL_W + 1;

   // configuration
   logic [COLOR_W-1:0] fg_ff;
   logic [COLOR_W-1:0] bg_ff;
   logic [ATTR_W-1:0]  attr;

   // latched item
   logic [OPCODE_W-1:0] op_ff;
   logic [CHAR_W-1:0]   char_ff;
   logic [CELL_W-1:0]   idx_ff;

   // cursor, with its column kept beside it
   logic [ADDR_W-1:0] cursor_ff;
   logic [ADDR_W-1:0] cursor_in;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic              scrolled_ff;
   logic              scrolled_in;

   // cell store
   logic [CELL_DATA_W-1:0] mem [CELLS];
   logic [CELL_DATA_W-1:0] rd_ff;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   put_wr;

   // sweep
   logic               sweep_act_ff;
   logic [ADDR_W-1:0]  sweep_cnt_ff;
   logic               sweep_shift_ff;
   logic               sweep_wr_ff;
   logic [ADDR_W-1:0]  sweep_wa_ff;
   logic               sweep_src_ff;
   logic [ATTR_W-1:0]  fill_attr_ff;
   logic               sweep_src;
   logic [CUR_X_W-1:0] sweep_src_addr;

   // cursor step
   logic                printable;
   logic                read_hit;
   logic [CUR_X_W-1:0]  cur_ext;
   logic [CUR_X_W-1:0]  cur_n;
   logic [CUR_X_W-1:0]  cur_s;
   logic [CUR_X_W-1:0]  tab_adv;
   logic [COL_X_W-1:0]  col_ext;
   logic [COL_X_W-1:0]  col_sum;
   logic [COL_W-1:0]    col_n;
   logic                scroll_need;

   assign attr      = {bg_ff, fg_ff};
   assign printable = (char_ff >= CH_BLANK) && (char_ff <= CH_LAST_PRINT);
   assign read_hit  = (op_ff == OP_READ) && (idx_ff < CELL_W'(CELLS));

   assign cur_ext = {1'b0, cursor_ff};
   assign col_ext = {1'b0, col_ff};
   assign tab_adv = CUR_X_W'(TAB_STOP) - CUR_X_W'(cursor_ff % TAB_STOP);

   always_comb begin
      cur_n   = cur_ext;
      col_n   = col_ff;
      col_sum = '0;
      case (char_ff)
         CH_BACKSPACE: begin
            if (cursor_ff != '0) begin
               cur_n = cur_ext - CUR_X_W'(1);
               col_n = (col_ff == '0) ? COL_W'(COLUMNS - 1) : col_ff - COL_W'(1);
            end
         end
         CH_TAB: begin
            cur_n   = cur_ext + tab_adv;
            col_sum = col_ext + COL_X_W'(tab_adv);
            col_n   = (col_sum >= COL_X_W'(COLUMNS)) ?
                      COL_W'(col_sum - COL_X_W'(COLUMNS)) : COL_W'(col_sum);
         end
         CH_CR: begin
            cur_n = cur_ext - CUR_X_W'(col_ff);
            col_n = '0;
         end
         CH_LINE_FEED: begin
            cur_n = cur_ext + CUR_X_W'(COLUMNS) - CUR_X_W'(col_ff);
            col_n = '0;
         end
         default: begin
            if (printable) begin
               cur_n = cur_ext + CUR_X_W'(1);
               col_n = (col_ff == COL_W'(COLUMNS - 1)) ? '0 : col_ff + COL_W'(1);
            end
         end
      endcase
   end

   assign scroll_need = (cur_n >= CUR_X_W'(CELLS));
   assign cur_s       = cur_n - CUR_X_W'(COLUMNS);

   always_comb begin
      cursor_in   = cursor_ff;
      col_in      = col_ff;
      scrolled_in = scrolled_ff;
      if (cmd.exec) begin
         scrolled_in = 1'b0;
         if (op_ff == OP_PUT) begin
            scrolled_in = scroll_need;
            if (!scroll_need) begin
               cursor_in = ADDR_W'(cur_n);
               col_in    = col_n;
            end else if (cur_s >= CUR_X_W'(CELLS)) begin
               // still past the end after one scroll: hold at the last cell
               cursor_in = ADDR_W'(CELLS - 1);
               col_in    = COL_W'(COLUMNS - 1);
            end else begin
               cursor_in = ADDR_W'(cur_s);
               col_in    = col_n;
            end
         end
      end
   end

   // sweep reads one row ahead when shifting; the last row comes out blank
   assign sweep_src      = sweep_shift_ff && (sweep_cnt_ff < ADDR_W'(CELLS - COLUMNS));
   assign sweep_src_addr = CUR_X_W'(sweep_cnt_ff) + CUR_X_W'(COLUMNS);

   assign put_wr  = cmd.exec && (op_ff == OP_PUT) && printable;
   assign rd_en   = (sweep_act_ff && sweep_src) || (cmd.exec && read_hit);
   assign rd_addr = sweep_act_ff ? ADDR_W'(sweep_src_addr) : idx_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (sweep_wr_ff) begin
         mem[sweep_wa_ff] <= {(sweep_src_ff ? rd_ff[CELL_DATA_W-1:ATTR_W] : CH_BLANK),
                              fill_attr_ff};
      end else if (put_wr) begin
         mem[cursor_ff] <= {char_ff, attr};
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // sweep sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_act_ff <= 1'b0;
         sweep_wr_ff  <= 1'b0;
      end else begin
         if (cmd.sweep_start) begin
            sweep_act_ff <= 1'b1;
         end else if (sweep_act_ff && (sweep_cnt_ff == ADDR_W'(CELLS - 1))) begin
            sweep_act_ff <= 1'b0;
         end
         sweep_wr_ff <= sweep_act_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep_start) begin
         sweep_cnt_ff   <= '0;
         sweep_shift_ff <= (op_ff == OP_PUT) && !cmd.fill_reset;
         fill_attr_ff   <= cmd.fill_reset ? RESET_ATTR : attr;
      end else if (sweep_act_ff) begin
         sweep_cnt_ff <= sweep_cnt_ff + ADDR_W'(1);
      end
      sweep_wa_ff  <= sweep_cnt_ff;
      sweep_src_ff <= sweep_src;
   end

   // item latch
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         char_ff <= req_char_code;
         idx_ff  <= req_cell_index;
      end
   end

   // configuration and cursor state
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff       <= RESET_FG;
         bg_ff       <= RESET_BG;
         cursor_ff   <= '0;
         col_ff      <= '0;
         scrolled_ff <= 1'b0;
      end else begin
         if (csr_wr_en && (csr_index == REG_FG_COLOR)) fg_ff <= csr_wr_data;
         if (csr_wr_en && (csr_index == REG_BG_COLOR)) bg_ff <= csr_wr_data;
         cursor_ff   <= cursor_in;
         col_ff      <= col_in;
         scrolled_ff <= scrolled_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_cursor_position <= CELL_W'(cursor_ff);
         rsp_read_char       <= read_hit ? rd_ff[CELL_DATA_W-1:ATTR_W] : '0;
         rsp_read_attribute  <= read_hit ? rd_ff[ATTR_W-1:0] : '0;
         rsp_scrolled        <= scrolled_ff;
      end
   end

   assign status.need_sweep = (op_ff == OP_CLEAR) || ((op_ff == OP_PUT) && scroll_need);
   assign status.sweep_done = sweep_wr_ff && (sweep_wa_ff == ADDR_W'(CELLS - 1));
   assign status.rsp_busy   = rsp_valid && !rsp_ready;

endmodule

FILE: hw/rtl/text_console_cursor_engine.sv
// Text console with an 80x25 store of character/attribute cells and a cursor.
// Requests arrive on req_* (valid/ready): req_opcode selects put character,
// read cell or clear screen; req_char_code and req_cell_index carry the byte
// and the cell to read. Every item gives one result on rsp_* (valid/ready):
// the cursor position after the item, the read cell (zero unless a read of a
// cell on the screen) and a flag for a scroll by one row.
// fg_color and bg_color are written through csr_wr_en/csr_index/csr_wr_data
// and form the attribute {bg, fg} of new cells, scrolls and clears.
// Sequence: an accepted item is executed with one store access, then its
// result is loaded into the output register; the next item can be accepted
// in the cycle after that load, so items are taken one at a time. A scroll
// or clear adds one pass over the store, one cell write per cycle, set by
// the single write port of the cell memory.
// Reset: after reset is released a clearing pass fills the store with blanks
// and attribute 0x0F; req_ready stays low until that pass is done.
// When the receiver stalls, the result waits in the output register; the next
// item is accepted and processed meanwhile and waits to load its result.
// Depends on tcce_pkg, tcce_ctrl and tcce_datapath.

module text_console_cursor_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tcce_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [tcce_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcce_pkg::CELL_W-1:0]    req_cell_index,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tcce_pkg::CELL_W-1:0]    rsp_cursor_position,
   output logic [tcce_pkg::CHAR_W-1:0]    rsp_read_char,
   output logic [tcce_pkg::ATTR_W-1:0]    rsp_read_attribute,
   output logic                           rsp_scrolled,
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [tcce_pkg::COLOR_W-1:0]   csr_wr_data
);
   import tcce_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcce_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_opcode          (req_opcode),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .cmd                 (cmd),
      .status              (status),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_read_char       (rsp_read_char),
      .rsp_read_attribute  (rsp_read_attribute),
      .rsp_scrolled        (rsp_scrolled)
   );

endmodule

FILE: hw/rtl/tcce_checker.sv
// tcce_checker: port-level assertions for the text console cursor engine,
// bound to the top level. Depends on tcce_pkg.

module tcce_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [tcce_pkg::OPCODE_W-1:0]  req_opcode,
   input logic [tcce_pkg::CHAR_W-1:0]    req_char_code,
   input logic [tcce_pkg::CELL_W-1:0]    req_cell_index,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [tcce_pkg::CELL_W-1:0]    rsp_cursor_position,
   input logic [tcce_pkg::CHAR_W-1:0]    rsp_read_char,
   input logic [tcce_pkg::ATTR_W-1:0]    rsp_read_attribute,
   input logic                           rsp_scrolled,
   input logic                           csr_wr_en,
   input logic                           csr_index,
   input logic [tcce_pkg::COLOR_W-1:0]   csr_wr_data
);
   import tcce_pkg::*;

   // reset starts the clearing pass: no item taken, no result shown
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("item or result open right after reset");

   // one item at a time: never ready in the cycle after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready in the cycle after an accept");

   // the cursor never leaves the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_position < CELL_W'(CELLS)))
      else $error("cursor position beyond the last cell");

   // only a put character scrolls, and it reads nothing
   a_scroll_no_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |-> (rsp_read_char == '0) && (rsp_read_attribute == '0))
      else $error("scroll reported together with read data");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_cursor_position) &&
                                    $stable(rsp_scrolled))
      else $error("stalled result changed");

endmodule

bind text_console_cursor_engine tcce_checker u_checker (.*);

FILE: bench/text_console_cursor_engine_tb.sv
// Self-checking bench for text_console_cursor_engine: drives put, read, clear
// and no-op items with random stalls and checks every result against a screen
// model kept here. Depends on tcce_pkg and the engine RTL.
`timescale 1ns / 100ps

module text_console_cursor_engine_tb;
   import tcce_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASE_ITEMS  = 140;

   typedef struct packed {
      logic [CELL_W-1:0] cursor_position;
      logic [CHAR_W-1:0] read_char;
      logic [ATTR_W-1:0] read_attribute;
      logic              scrolled;
   } console_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OPCODE_W-1:0] req_opcode = OP_PUT;
   logic [CHAR_W-1:0]   req_char_code = '0;
   logic [CELL_W-1:0]   req_cell_index = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [CELL_W-1:0]   rsp_cursor_position;
   logic [CHAR_W-1:0]   rsp_read_char;
   logic [ATTR_W-1:0]   rsp_read_attribute;
   logic                rsp_scrolled;
   logic                csr_wr_en = 1'b0;
   logic                csr_index = REG_FG_COLOR;
   logic [COLOR_W-1:0]  csr_wr_data = '0;

   // screen model
   logic [CHAR_W-1:0]  screen_char [CELLS];
   logic [ATTR_W-1:0]  screen_attr [CELLS];
   int                 screen_cursor = 0;
   logic [COLOR_W-1:0] model_fg = RESET_FG;
   logic [COLOR_W-1:0] model_bg = RESET_BG;

   console_rsp_type pending_rsp[$];
   int  error_count = 0;
   int  items_sent = 0;
   int  scroll_count = 0;
   int  clear_count = 0;
   int  read_count = 0;
   int  setting_count = 0;
   bit  steady = 1'b0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   int  hold_left = 0;

   text_console_cursor_engine dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_read_char       (rsp_read_char),
      .rsp_read_attribute  (rsp_read_attribute),
      .rsp_scrolled        (rsp_scrolled),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [ATTR_W-1:0] color_attr();
      return {model_bg, model_fg};
   endfunction

   // advances the screen model by one item and returns the result it should give
   function automatic console_rsp_type console_step(input logic [OPCODE_W-1:0] op,
                                                    input logic [CHAR_W-1:0]   ch,
                                                    input logic [CELL_W-1:0]   idx);
      console_rsp_type r;
      int c;
      r = '0;
      case (op)
         OP_PUT: begin
            case (ch)
               CH_BACKSPACE: if (screen_cursor > 0) screen_cursor--;
               CH_TAB:       screen_cursor += TAB_STOP - (screen_cursor % TAB_STOP);
               CH_CR:        screen_cursor -= screen_cursor % COLUMNS;
               CH_LINE_FEED: screen_cursor += COLUMNS - (screen_cursor % COLUMNS);
               default: begin
                  if (ch >= CH_BLANK && ch <= CH_LAST_PRINT) begin
                     if (screen_cursor < CELLS) begin
                        screen_char[screen_cursor] = ch;
                        screen_attr[screen_cursor] = color_attr();
                     end
                     screen_cursor++;
                  end
               end
            endcase
            // end of screen: shift up a row, blank the last one, recolor everything
            if (screen_cursor >= CELLS) begin
               for (c = 0; c < CELLS; c++) begin
                  screen_char[c] = (c < CELLS - COLUMNS) ? screen_char[c + COLUMNS] : CH_BLANK;
                  screen_attr[c] = color_attr();
               end
               screen_cursor -= COLUMNS;
               if (screen_cursor >= CELLS) screen_cursor = CELLS - 1;
               r.scrolled = 1'b1;
               scroll_count++;
            end
         end
         OP_READ: begin
            read_count++;
            if (idx < CELLS) begin
               r.read_char      = screen_char[idx];
               r.read_attribute = screen_attr[idx];
            end
         end
         OP_CLEAR: begin
            clear_count++;
            for (c = 0; c < CELLS; c++) begin
               screen_char[c] = CH_BLANK;
               screen_attr[c] = color_attr();
            end
         end
         default: ;
      endcase
      r.cursor_position = CELL_W'(screen_cursor);
      return r;
   endfunction

   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic [CELL_W-1:0] idx);
      if (!steady && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 25);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_char_code  <= ch;
      req_cell_index <= idx;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(console_step(op, ch, idx));
      items_sent++;
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // only called with nothing in flight
   task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
      csr_wr_en   <= 1'b1;
      csr_index   <= REG_FG_COLOR;
      csr_wr_data <= fg;
      @(posedge clock);
      csr_index   <= REG_BG_COLOR;
      csr_wr_data <= bg;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_fg = fg;
      model_bg = bg;
      setting_count++;
   endtask

   task automatic send_random_item();
      int pick;
      int near;
      logic [CHAR_W-1:0] ch;
      logic [CELL_W-1:0] idx;
      pick = $urandom_range(99);
      ch   = CHAR_W'($urandom_range(255));
      idx  = CELL_W'($urandom_range((1 << CELL_W) - 1));
      if (pick < 55) begin
         ch = CHAR_W'($urandom_range(CH_LAST_PRINT, CH_BLANK));
         send_item(OP_PUT, ch, idx);
      end else if (pick < 65) send_item(OP_PUT, CH_LINE_FEED, idx);
      else if (pick < 69) send_item(OP_PUT, CH_CR, idx);
      else if (pick < 73) send_item(OP_PUT, CH_TAB, idx);
      else if (pick < 77) send_item(OP_PUT, CH_BACKSPACE, idx);
      else if (pick < 82) send_item(OP_PUT, ch, idx);
      else if (pick < 94) begin
         // mostly read back just behind the cursor where text was written
         if (pick < 90) begin
            near = screen_cursor - int'($urandom_range(160));
            if (near < 0) near = 0;
            idx = CELL_W'(near);
         end
         send_item(OP_READ, ch, idx);
      end else if (pick < 96) send_item(OP_CLEAR, ch, idx);
      else send_item(OP_NOP, ch, idx);
   endtask

   task automatic test_control_codes();
      send_item(OP_PUT, CH_BACKSPACE, '0);          // held at the first cell
      send_item(OP_READ, '0, '0);
      send_item(OP_PUT, CH_BLANK, '0);
      send_item(OP_PUT, CH_LAST_PRINT, '0);
      send_item(OP_PUT, 8'h41, '0);
      send_item(OP_PUT, 8'h00, '0);                 // ignored bytes
      send_item(OP_PUT, 8'h1F, '0);
      send_item(OP_PUT, 8'h80, '0);
      send_item(OP_PUT, 8'hFF, '1);
      send_item(OP_PUT, CH_TAB, '0);
      send_item(OP_PUT, CH_TAB, '0);
      send_item(OP_PUT, 8'h78, '0);
      send_item(OP_PUT, CH_CR, '0);
      send_item(OP_PUT, CH_LINE_FEED, '0);
      send_item(OP_PUT, CH_BACKSPACE, '0);          // back across the row start
      send_item(OP_READ, '0, CELL_W'(1));
      send_item(OP_READ, '0, CELL_W'(CELLS - 1));
      send_item(OP_READ, '0, CELL_W'(CELLS));       // off the screen
      send_item(OP_READ, '1, '1);
      send_item(OP_NOP, '1, '1);
      send_item(OP_CLEAR, '0, '0);                  // cursor stays put
      send_item(OP_READ, '0, CELL_W'(1));
      wait_results();
   endtask

   task automatic test_screen_end();
      set_colors('0, '1);
      send_item(OP_PUT, CH_CR, '0);
      repeat (ROWS - 1) send_item(OP_PUT, CH_LINE_FEED, '0);
      repeat (9) send_item(OP_PUT, CH_TAB, '0);
      // printable into the last cell scrolls
      repeat (8) send_item(OP_PUT, CHAR_W'($urandom_range(CH_LAST_PRINT, CH_BLANK)), '0);
      send_item(OP_PUT, CH_LINE_FEED, '0);
      repeat (COLUMNS / TAB_STOP) send_item(OP_PUT, CH_TAB, '0);
      send_item(OP_READ, '0, CELL_W'(CELLS - 2 * COLUMNS));
      send_item(OP_READ, '0, CELL_W'(CELLS - COLUMNS - 1));
      send_item(OP_READ, '0, CELL_W'(CELLS - 1));
      send_item(OP_PUT, CH_BACKSPACE, '0);
      send_item(OP_PUT, CH_CR, '0);
      wait_results();
   endtask

   task automatic test_random_text();
      int phase;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       set_colors(RESET_FG, RESET_BG);
            1:       set_colors('0, '0);
            2:       set_colors('1, '1);
            default: set_colors(COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)));
         endcase
         steady = (phase == 2);
         repeat (PHASE_ITEMS) send_random_item();
         wait_results();
      end
      steady = 1'b0;
   endtask

   // receiver holds off while items keep coming, so the engine backs up
   task automatic test_backpressure();
      steady = 1'b1;
      hold_toggle <= ~hold_toggle;
      repeat (12) send_random_item();
      wait_results();
      steady = 1'b0;
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      console_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result with no item outstanding: cursor_position %0d", rsp_cursor_position);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_cursor_position !== want.cursor_position) begin
               $error("cursor_position: expected %0d, actual %0d",
                      want.cursor_position, rsp_cursor_position);
               error_count++;
            end
            if (rsp_read_char !== want.read_char) begin
               $error("read_char: expected 0x%02h, actual 0x%02h",
                      want.read_char, rsp_read_char);
               error_count++;
            end
            if (rsp_read_attribute !== want.read_attribute) begin
               $error("read_attribute: expected 0x%02h, actual 0x%02h",
                      want.read_attribute, rsp_read_attribute);
               error_count++;
            end
            if (rsp_scrolled !== want.scrolled) begin
               $error("scrolled: expected %0d, actual %0d", want.scrolled, rsp_scrolled);
               error_count++;
            end
         end
      end
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 25);
      end
   end

   initial begin
      #(100_000_000);
      $display("timeout with %0d results outstanding", pending_rsp.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      for (int c = 0; c < CELLS; c++) begin
         screen_char[c] = CH_BLANK;
         screen_attr[c] = RESET_ATTR;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_control_codes();
      test_screen_end();
      test_random_text();
      test_backpressure();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("checked %0d items: %0d scrolls, %0d clears, %0d cell reads",
               items_sent, scroll_count, clear_count, read_count);
      $display("across %0d color settings, with random and long output stalls", setting_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_ctrl.sv
hw/rtl/tcce_datapath.sv
hw/rtl/text_console_cursor_engine.sv
hw/rtl/tcce_checker.sv
bench/text_console_cursor_engine_tb.sv
